### src/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every rising clock edge outside reset
`define RWCS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rwcs assertion failed");

// condition must never be true outside reset
`define RWCS_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("rwcs forbidden condition");

`endif

### src/rwcs_pkg.sv
// shared constants, types and helpers of the wall column setup core
`default_nettype none
package rwcs_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CFG_W     = 13;
    localparam int POS_W     = 32;
    localparam int COL_W     = 12;
    localparam int DIR_W     = 19;
    localparam int HGT_W     = 24;
    localparam int STEP_W    = 28;
    localparam int TIDX_W    = 2;
    localparam int CIDX_W    = 3;

    localparam int DIV_NUM_W = CFG_W + FRAC_BITS;
    localparam int DIV_DEN_W = POS_W;
    localparam int PROD_W    = POS_W + 1 + DIR_W;
    localparam int FX_W      = PROD_W + 1;
    localparam int HX_W      = FX_W - FRAC_BITS;
    localparam int TCP_W     = FRAC_BITS + CFG_W;
    localparam int SP_W      = HGT_W + STEP_W;

    localparam logic [COL_W-1:0]  MAX_COL  = '1;
    localparam logic [HGT_W-1:0]  MAX_HGT  = '1;
    localparam logic [STEP_W-1:0] MAX_STEP = '1;
    localparam logic [POS_W-1:0]  MAX_POS  = '1;

    localparam logic [TIDX_W-1:0] TEX_NORTH = 2'd0;
    localparam logic [TIDX_W-1:0] TEX_SOUTH = 2'd1;
    localparam logic [TIDX_W-1:0] TEX_WEST  = 2'd2;
    localparam logic [TIDX_W-1:0] TEX_EAST  = 2'd3;

    typedef enum logic [CIDX_W-1:0] {
        CFG_SCREEN_H = 3'd0,
        CFG_TEX_W    = 3'd1,
        CFG_TEX_H    = 3'd2,
        CFG_PLAYER_X = 3'd3,
        CFG_PLAYER_Y = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] screen_h;
        logic [CFG_W-1:0] tex_w;
        logic [CFG_W-1:0] tex_h;
        logic [POS_W-1:0] player_x;
        logic [POS_W-1:0] player_y;
    } t_cfg;

    typedef struct packed {
        logic [COL_W-1:0]     column;
        logic                 side;
        logic [POS_W-1:0]     perp;
        logic [TIDX_W-1:0]    tidx;
        logic [FRAC_BITS-1:0] frac;
        logic [COL_W-1:0]     tcol;
        logic [POS_W-1:0]     hit_x;
        logic [POS_W-1:0]     hit_y;
        logic [HGT_W-1:0]     height;
        logic [COL_W-1:0]     top;
        logic [COL_W-1:0]     bot;
        logic [HGT_W-1:0]     off;
    } t_item;

    function automatic logic [POS_W-1:0] sat_hit(input logic signed [HX_W-1:0] v);
        logic [POS_W-1:0] r;
        if (v[HX_W-1]) begin
            r = '0;
        end else if (|v[HX_W-2:POS_W]) begin
            r = MAX_POS;
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### src/raycast_wall_column_setup_core.sv
// pipeline from input request to result: 4 front, 29 + 29 divider stages, 4 back
// throughput: one column per cycle while the output is not stalled; each divider retires one quotient bit per stage
// a stalled output backs up stage by stage; empty stages keep taking requests
// reset: synchronous active-low i_rst_n empties every stage and loads register defaults
// defaults: screen height 1024, texture 64 by 64, player at the origin
`default_nettype none
`include "assert_macros.svh"
module raycast_wall_column_setup_core import rwcs_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [31:0]   i_cfg_data,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    // column, perp_distance, ray_dir_x, ray_dir_y, zero pad
    input  wire logic [87:0]   i_s_tdata,
    // side
    input  wire logic [0:0]    i_s_tuser,
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    // column_out, wall_height, draw_top, draw_bottom, texture_column,
    // texture_step, texture_start, wall_fraction, hit_x, hit_y
    output logic [207:0]       o_m_tdata,
    // texture_index
    output logic [1:0]         o_m_tuser
);

    t_cfg r_cfg;

    logic  w_front_ready, w_front_valid;
    t_item w_front_item;
    logic  w_div1_ready, w_div1_valid;
    t_item w_div1_item;
    logic [DIV_NUM_W-1:0] w_q1;
    logic  w_div2_ready, w_div2_valid;
    t_item w_div2_item;
    logic [DIV_NUM_W-1:0] w_q2;
    logic [DIV_DEN_W-1:0] w_den1;

    logic r_b_v, r_c_v, r_d_v, r_o_v;
    logic w_rdy_b, w_rdy_c, w_rdy_d, w_rdy_o;
    t_item r_b_item, r_c_item, r_d_item, r_o_item;
    logic [STEP_W-1:0] r_c_step, r_d_step, r_o_step, r_o_start;
    logic [SP_W-1:0]   r_d_prod;

    t_item n_b_item;
    logic [HGT_W-1:0]   w_h;
    logic [HGT_W-2:0]   w_hh;
    logic [CFG_W-2:0]   w_sh;
    logic [HGT_W-1:0]   w_bsum;
    logic [HGT_W-1:0]   w_bot;
    logic [STEP_W-1:0]  n_c_step;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_h <= CFG_W'(1024);
            r_cfg.tex_w    <= CFG_W'(64);
            r_cfg.tex_h    <= CFG_W'(64);
            r_cfg.player_x <= '0;
            r_cfg.player_y <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SCREEN_H: r_cfg.screen_h <= i_cfg_data[CFG_W-1:0];
                CFG_TEX_W:    r_cfg.tex_w    <= i_cfg_data[CFG_W-1:0];
                CFG_TEX_H:    r_cfg.tex_h    <= i_cfg_data[CFG_W-1:0];
                CFG_PLAYER_X: r_cfg.player_x <= i_cfg_data[POS_W-1:0];
                CFG_PLAYER_Y: r_cfg.player_y <= i_cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    rwcs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_s_tvalid),
        .o_ready  (w_front_ready),
        .i_column (i_s_tdata[11:0]),
        .i_side   (i_s_tuser[0]),
        .i_perp   (i_s_tdata[43:12]),
        .i_rdx    ($signed(i_s_tdata[62:44])),
        .i_rdy    ($signed(i_s_tdata[81:63])),
        .o_valid  (w_front_valid),
        .i_ready  (w_div1_ready),
        .o_item   (w_front_item)
    );

    assign o_s_tready = w_front_ready;

    // distance clamped to one lsb
    assign w_den1 = (w_front_item.perp == '0) ? DIV_DEN_W'(1) : w_front_item.perp;

    rwcs_divider u_div_height (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_front_valid),
        .o_ready (w_div1_ready),
        .i_item  (w_front_item),
        .i_num   ({r_cfg.screen_h, {FRAC_BITS{1'b0}}}),
        .i_den   (w_den1),
        .o_valid (w_div1_valid),
        .i_ready (w_rdy_b),
        .o_item  (w_div1_item),
        .o_quot  (w_q1)
    );

    // height, clipped rows and row offset
    always_comb begin
        w_h    = (|w_q1[DIV_NUM_W-1:HGT_W]) ? MAX_HGT : w_q1[HGT_W-1:0];
        w_hh   = w_h[HGT_W-1:1];
        w_sh   = r_cfg.screen_h[CFG_W-1:1];
        w_bsum = HGT_W'(w_hh) + HGT_W'(w_sh);
        if (r_cfg.screen_h == '0) begin
            w_bot = '0;
        end else if (w_bsum >= HGT_W'(r_cfg.screen_h)) begin
            w_bot = HGT_W'(r_cfg.screen_h - CFG_W'(1));
        end else begin
            w_bot = w_bsum;
        end
        n_b_item        = w_div1_item;
        n_b_item.height = w_h;
        n_b_item.bot    = (|w_bot[HGT_W-1:COL_W]) ? MAX_COL : w_bot[COL_W-1:0];
        if (HGT_W'(w_sh) > HGT_W'(w_hh)) begin
            n_b_item.top = COL_W'(HGT_W'(w_sh) - HGT_W'(w_hh));
            n_b_item.off = '0;
        end else begin
            n_b_item.top = '0;
            n_b_item.off = HGT_W'(w_hh) - HGT_W'(w_sh);
        end
    end

    assign w_rdy_b = !r_b_v || w_div2_ready;

    rwcs_divider u_div_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_b_v),
        .o_ready (w_div2_ready),
        .i_item  (r_b_item),
        .i_num   ({r_cfg.tex_h, {FRAC_BITS{1'b0}}}),
        .i_den   (DIV_DEN_W'(r_b_item.height)),
        .o_valid (w_div2_valid),
        .i_ready (w_rdy_c),
        .o_item  (w_div2_item),
        .o_quot  (w_q2)
    );

    // zero height divides by zero: all-ones quotient saturates the step
    assign n_c_step = (|w_q2[DIV_NUM_W-1:STEP_W]) ? MAX_STEP : w_q2[STEP_W-1:0];

    assign w_rdy_o = !r_o_v || i_m_tready;
    assign w_rdy_d = !r_d_v || w_rdy_o;
    assign w_rdy_c = !r_c_v || w_rdy_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (w_rdy_b) r_b_v <= w_div1_valid;
            if (w_rdy_c) r_c_v <= w_div2_valid;
            if (w_rdy_d) r_d_v <= r_c_v;
            if (w_rdy_o) r_o_v <= r_d_v;
        end
        if (w_rdy_b) r_b_item <= n_b_item;
        if (w_rdy_c) begin
            r_c_item <= w_div2_item;
            r_c_step <= n_c_step;
        end
        if (w_rdy_d) begin
            r_d_item <= r_c_item;
            r_d_step <= r_c_step;
            r_d_prod <= SP_W'(r_c_item.off) * SP_W'(r_c_step);
        end
        if (w_rdy_o) begin
            r_o_item  <= r_d_item;
            r_o_step  <= r_d_step;
            r_o_start <= (|r_d_prod[SP_W-1:STEP_W]) ? MAX_STEP : r_d_prod[STEP_W-1:0];
        end
    end

    assign o_m_tvalid = r_o_v;
    assign o_m_tuser  = r_o_item.tidx;
    assign o_m_tdata  = {r_o_item.hit_y, r_o_item.hit_x, r_o_item.frac, r_o_start, r_o_step,
                         r_o_item.tcol, r_o_item.bot, r_o_item.top, r_o_item.height,
                         r_o_item.column};

    `RWCS_ASSERT(a_zero_height_step, i_clk, i_rst_n,
        (r_o_v && (r_o_item.height == '0)) |-> ((r_o_step == MAX_STEP) && (r_o_start == '0)))
    `RWCS_ASSERT(a_backpressure_full, i_clk, i_rst_n,
        !o_s_tready |-> (o_m_tvalid && !i_m_tready))
    `RWCS_NEVER(a_top_below_half, i_clk, i_rst_n,
        r_o_v && (r_o_item.off != '0) && (r_o_item.top != '0))

endmodule
`default_nettype wire

### src/rwcs_front.sv
// front stages: hit point, wall fraction, texture choice and texture column
`default_nettype none
module rwcs_front import rwcs_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_cfg                    i_cfg,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [COL_W-1:0]        i_column,
    input  wire logic                    i_side,
    input  wire logic [POS_W-1:0]        i_perp,
    input  wire logic signed [DIR_W-1:0] i_rdx,
    input  wire logic signed [DIR_W-1:0] i_rdy,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output t_item                        o_item
);

    logic [3:0] r_v;
    logic [4:0] w_rdy;

    logic [COL_W-1:0]         r1_column;
    logic                     r1_side;
    logic [POS_W-1:0]         r1_perp;
    logic [TIDX_W-1:0]        r1_tidx;
    logic signed [PROD_W-1:0] r1_px;
    logic signed [PROD_W-1:0] r1_py;

    logic [COL_W-1:0]         r2_column;
    logic                     r2_side;
    logic [POS_W-1:0]         r2_perp;
    logic [TIDX_W-1:0]        r2_tidx;
    logic signed [FX_W-1:0]   r2_fx;
    logic signed [FX_W-1:0]   r2_fy;

    t_item r3_item;
    t_item r4_item;

    logic [TIDX_W-1:0]        n1_tidx;
    logic signed [FX_W-1:0]   n2_fx;
    logic signed [FX_W-1:0]   n2_fy;
    t_item                    n3_item;
    t_item                    n4_item;
    logic [TCP_W-1:0]         w_tcp;

    assign w_rdy[4] = i_ready;
    assign w_rdy[3] = !r_v[3] || w_rdy[4];
    assign w_rdy[2] = !r_v[2] || w_rdy[3];
    assign w_rdy[1] = !r_v[1] || w_rdy[2];
    assign w_rdy[0] = !r_v[0] || w_rdy[1];

    always_comb begin
        if (!i_side) begin
            n1_tidx = (!i_rdx[DIR_W-1] && (|i_rdx)) ? TEX_WEST : TEX_EAST;
        end else begin
            n1_tidx = (!i_rdy[DIR_W-1] && (|i_rdy)) ? TEX_SOUTH : TEX_NORTH;
        end
    end

    assign n2_fx = $signed({{(FX_W-POS_W-FRAC_BITS){1'b0}}, i_cfg.player_x, {FRAC_BITS{1'b0}}})
                 + $signed({{(FX_W-PROD_W){r1_px[PROD_W-1]}}, r1_px});
    assign n2_fy = $signed({{(FX_W-POS_W-FRAC_BITS){1'b0}}, i_cfg.player_y, {FRAC_BITS{1'b0}}})
                 + $signed({{(FX_W-PROD_W){r1_py[PROD_W-1]}}, r1_py});

    always_comb begin
        n3_item        = '0;
        n3_item.column = r2_column;
        n3_item.side   = r2_side;
        n3_item.perp   = r2_perp;
        n3_item.tidx   = r2_tidx;
        n3_item.frac   = r2_side ? r2_fx[2*FRAC_BITS-1:FRAC_BITS]
                                 : r2_fy[2*FRAC_BITS-1:FRAC_BITS];
        n3_item.hit_x  = sat_hit(r2_fx[FX_W-1:FRAC_BITS]);
        n3_item.hit_y  = sat_hit(r2_fy[FX_W-1:FRAC_BITS]);
    end

    assign w_tcp = TCP_W'(r3_item.frac) * TCP_W'(i_cfg.tex_w);

    always_comb begin
        n4_item      = r3_item;
        n4_item.tcol = (|w_tcp[TCP_W-1:FRAC_BITS+COL_W]) ? MAX_COL
                                                          : w_tcp[FRAC_BITS+COL_W-1:FRAC_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) r_v[0] <= i_valid;
            if (w_rdy[1]) r_v[1] <= r_v[0];
            if (w_rdy[2]) r_v[2] <= r_v[1];
            if (w_rdy[3]) r_v[3] <= r_v[2];
        end
        if (w_rdy[0]) begin
            r1_column <= i_column;
            r1_side   <= i_side;
            r1_perp   <= i_perp;
            r1_tidx   <= n1_tidx;
            r1_px     <= $signed({1'b0, i_perp}) * i_rdx;
            r1_py     <= $signed({1'b0, i_perp}) * i_rdy;
        end
        if (w_rdy[1]) begin
            r2_column <= r1_column;
            r2_side   <= r1_side;
            r2_perp   <= r1_perp;
            r2_tidx   <= r1_tidx;
            r2_fx     <= n2_fx;
            r2_fy     <= n2_fy;
        end
        if (w_rdy[2]) r3_item <= n3_item;
        if (w_rdy[3]) r4_item <= n4_item;
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[3];
    assign o_item  = r4_item;

endmodule
`default_nettype wire

### src/rwcs_divider.sv
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
`include "assert_macros.svh"
module rwcs_divider import rwcs_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire t_item                i_item,
    input  wire logic [DIV_NUM_W-1:0] i_num,
    input  wire logic [DIV_DEN_W-1:0] i_den,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output t_item                     o_item,
    output logic [DIV_NUM_W-1:0]      o_quot
);

    localparam int NS = DIV_NUM_W;

    logic [NS-1:0]          r_v;
    t_item                  r_item [NS];
    logic [DIV_DEN_W-1:0]   r_rem  [NS];
    logic [DIV_DEN_W-1:0]   r_den  [NS];
    logic [DIV_NUM_W-1:0]   r_num  [NS];
    logic [DIV_NUM_W-1:0]   r_quot [NS];

    logic [NS:0]            w_rdy;
    logic [NS-1:0]          w_vin;
    t_item                  w_item [NS];
    logic [DIV_DEN_W-1:0]   w_rem  [NS];
    logic [DIV_DEN_W-1:0]   w_den  [NS];
    logic [DIV_NUM_W-1:0]   w_num  [NS];
    logic [DIV_NUM_W-1:0]   w_quot [NS];
    logic [DIV_DEN_W:0]     w_trial [NS];
    logic [DIV_DEN_W:0]     w_diff  [NS];
    logic [NS-1:0]          w_take;
    logic [DIV_DEN_W-1:0]   n_rem  [NS];
    logic [DIV_NUM_W-1:0]   n_quot [NS];

    always_comb begin
        w_rdy[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    always_comb begin
        for (int k = 0; k < NS; k++) begin
            if (k == 0) begin
                w_vin[k]  = i_valid;
                w_item[k] = i_item;
                w_rem[k]  = '0;
                w_den[k]  = i_den;
                w_num[k]  = i_num;
                w_quot[k] = '0;
            end else begin
                w_vin[k]  = r_v[k-1];
                w_item[k] = r_item[k-1];
                w_rem[k]  = r_rem[k-1];
                w_den[k]  = r_den[k-1];
                w_num[k]  = r_num[k-1];
                w_quot[k] = r_quot[k-1];
            end
            w_trial[k] = {w_rem[k], w_num[k][NS-1-k]};
            w_diff[k]  = w_trial[k] - {1'b0, w_den[k]};
            w_take[k]  = w_trial[k] >= {1'b0, w_den[k]};
            n_rem[k]   = w_take[k] ? w_diff[k][DIV_DEN_W-1:0] : w_trial[k][DIV_DEN_W-1:0];
            n_quot[k]  = {w_quot[k][DIV_NUM_W-2:0], w_take[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (w_rdy[k]) r_v[k] <= w_vin[k];
            end
        end
        for (int k = 0; k < NS; k++) begin
            if (w_rdy[k]) begin
                r_item[k] <= w_item[k];
                r_rem[k]  <= n_rem[k];
                r_den[k]  <= w_den[k];
                r_num[k]  <= w_num[k];
                r_quot[k] <= n_quot[k];
            end
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[NS-1];
    assign o_item  = r_item[NS-1];
    assign o_quot  = r_quot[NS-1];

    `RWCS_ASSERT(a_rem_below_den, i_clk, i_rst_n,
        (r_v[NS-1] && (r_den[NS-1] != '0)) |-> (r_rem[NS-1] < r_den[NS-1]))
    `RWCS_ASSERT(a_stall_holds_last, i_clk, i_rst_n,
        (r_v[NS-1] && !i_ready) |=> (r_v[NS-1] && $stable(r_quot[NS-1])))
    `RWCS_NEVER(a_zero_den_full_quot, i_clk, i_rst_n,
        r_v[NS-1] && (r_den[NS-1] == '0) && (r_quot[NS-1] != '1))

endmodule
`default_nettype wire

### tb/testbench.sv
// self-checking testbench of the raycast wall column setup core
`default_nettype none
module testbench;
    import rwcs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CIDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int IDLE_WAIT = 80;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic [11:0]        column;
        logic               side;
        logic [31:0]        perp;
        logic signed [18:0] rdx;
        logic signed [18:0] rdy;
    } t_ray;

    typedef struct packed {
        logic [11:0] column;
        logic [23:0] height;
        logic [11:0] top;
        logic [11:0] bot;
        logic [1:0]  tidx;
        logic [11:0] tcol;
        logic [27:0] step;
        logic [27:0] start;
        logic [15:0] frac;
        logic [31:0] hit_x;
        logic [31:0] hit_y;
    } t_slice;

    class slice_board;
        longint unsigned scr_h, tex_w, tex_h, pos_x, pos_y;
        t_slice slices_due[$];
        int errors;

        function new();
            scr_h = 1024;
            tex_w = 64;
            tex_h = 64;
            pos_x = 0;
            pos_y = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [CIDX_W-1:0] idx, logic [31:0] val);
            case (idx)
                CFG_SCREEN_H: scr_h = val[12:0];
                CFG_TEX_W:    tex_w = val[12:0];
                CFG_TEX_H:    tex_h = val[12:0];
                CFG_PLAYER_X: pos_x = val;
                CFG_PLAYER_Y: pos_y = val;
                default: ;
            endcase
        endfunction

        function longint unsigned clamp_pos(longint v);
            if (v < 0) return 0;
            if (v > 64'hFFFF_FFFF) return 64'hFFFF_FFFF;
            return v;
        endfunction

        function void note_ray(t_ray r);
            longint unsigned den, h, hh, sh, top, bot, tcol, step, start, frac;
            longint dx, dy, fx, fy, hx, hy;
            t_slice s;
            dx = r.rdx;
            dy = r.rdy;
            den = (r.perp == 0) ? 1 : r.perp;
            h = (scr_h << 16) / den;
            if (h > 24'hFF_FFFF) h = 24'hFF_FFFF;
            hh = h / 2;
            sh = scr_h / 2;
            top = (sh > hh) ? sh - hh : 0;
            bot = hh + sh;
            if (scr_h == 0) bot = 0;
            else if (bot >= scr_h) bot = scr_h - 1;
            if (bot > 4095) bot = 4095;
            if (r.side == 1'b0) s.tidx = (dx > 0) ? TEX_WEST : TEX_EAST;
            else s.tidx = (dy > 0) ? TEX_SOUTH : TEX_NORTH;
            fx = longint'(pos_x << 16) + longint'(r.perp) * dx;
            fy = longint'(pos_y << 16) + longint'(r.perp) * dy;
            hx = fx >>> 16;
            hy = fy >>> 16;
            frac = ((r.side == 1'b0) ? hy : hx) & 64'hFFFF;
            tcol = (frac * tex_w) >> 16;
            if (tcol > 4095) tcol = 4095;
            if (h == 0) begin
                step = 28'hFFF_FFFF;
                start = 0;
            end else begin
                step = (tex_h << 16) / h;
                if (step > 28'hFFF_FFFF) step = 28'hFFF_FFFF;
                start = (top + hh - sh) * step;
                if (start > 28'hFFF_FFFF) start = 28'hFFF_FFFF;
            end
            s.column = r.column;
            s.height = 24'(h);
            s.top = 12'(top);
            s.bot = 12'(bot);
            s.tcol = 12'(tcol);
            s.step = 28'(step);
            s.start = 28'(start);
            s.frac = 16'(frac);
            s.hit_x = 32'(clamp_pos(hx));
            s.hit_y = 32'(clamp_pos(hy));
            slices_due.push_back(s);
        endfunction

        function void cmp(string name, logic [31:0] e, logic [31:0] a);
            if (e !== a) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, e, a);
                errors++;
            end
        endfunction

        function void check_slice(logic [207:0] d, logic [1:0] u);
            t_slice e;
            if (slices_due.size() == 0) begin
                $error("result with no request pending");
                errors++;
                return;
            end
            e = slices_due.pop_front();
            cmp("column_out", e.column, d[11:0]);
            cmp("wall_height", e.height, d[35:12]);
            cmp("draw_top", e.top, d[47:36]);
            cmp("draw_bottom", e.bot, d[59:48]);
            cmp("texture_index", e.tidx, u);
            cmp("texture_column", e.tcol, d[71:60]);
            cmp("texture_step", e.step, d[99:72]);
            cmp("texture_start", e.start, d[127:100]);
            cmp("wall_fraction", e.frac, d[143:128]);
            cmp("hit_x", e.hit_x, d[175:144]);
            cmp("hit_y", e.hit_y, d[207:176]);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [2:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic i_s_tvalid = 1'b0;
    logic [87:0] i_s_tdata = '0;
    logic [0:0] i_s_tuser = '0;
    logic i_m_tready = 1'b0;
    logic o_cfg_ready, o_s_tready, o_m_tvalid;
    logic [207:0] o_m_tdata;
    logic [1:0] o_m_tuser;

    raycast_wall_column_setup_core dut (
        .i_clk, .i_rst_n, .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .i_s_tvalid, .o_s_tready, .i_s_tdata, .i_s_tuser,
        .o_m_tvalid, .i_m_tready, .o_m_tdata, .o_m_tuser
    );

    slice_board board = new();
    int burst_left = 0;
    int idle_cycles = 0;
    int stall_mode = 0;
    int mode_cycles = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            board.check_slice(o_m_tdata, o_m_tuser);
        end
        if (mode_cycles == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_cycles <= $urandom_range(20, 300);
        end else begin
            mode_cycles <= mode_cycles - 1;
        end
        case (stall_mode)
            0: i_m_tready <= 1'b1;
            1: i_m_tready <= ($urandom_range(0, 3) != 0);
            2: i_m_tready <= ($urandom_range(0, 3) == 0);
            default: i_m_tready <= mode_cycles[2];
        endcase
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        board.set_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        while (board.slices_due.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic setup(logic [31:0] sh, logic [31:0] tw, logic [31:0] th,
                         logic [31:0] px, logic [31:0] py);
        drain();
        write_reg(CFG_SCREEN_H, sh);
        write_reg(CFG_TEX_W, tw);
        write_reg(CFG_TEX_H, th);
        write_reg(CFG_PLAYER_X, px);
        write_reg(CFG_PLAYER_Y, py);
    endtask

    task automatic send_ray(t_ray r);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 12);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tuser <= r.side;
        i_s_tdata <= {6'd0, r.rdy, r.rdx, r.perp, r.column};
        forever begin
            @(posedge i_clk);
            if (o_s_tready) break;
        end
        board.note_ray(r);
    endtask

    function automatic t_ray make_ray(logic [11:0] c, logic s, logic [31:0] p,
                                      logic [18:0] x, logic [18:0] y);
        t_ray r;
        r.column = c;
        r.side = s;
        r.perp = p;
        r.rdx = x;
        r.rdy = y;
        return r;
    endfunction

    function automatic t_ray rand_ray();
        t_ray r;
        r.column = 12'($urandom);
        r.side = 1'($urandom);
        case ($urandom_range(0, 4))
            0: r.perp = $urandom;
            1: r.perp = $urandom_range(0, 3);
            2: r.perp = $urandom_range(32'h8000, 32'h8_0000);
            default: r.perp = $urandom_range(0, 32'h3_FFFF);
        endcase
        if ($urandom_range(0, 1)) begin
            r.rdx = 19'($urandom);
            r.rdy = 19'($urandom);
        end else begin
            r.rdx = 19'($signed($urandom_range(0, 32'h2_0000)) - 32'sh1_0000);
            r.rdy = 19'($signed($urandom_range(0, 32'h2_0000)) - 32'sh1_0000);
        end
        if ($urandom_range(0, 15) == 0) r.rdx = '0;
        if ($urandom_range(0, 15) == 0) r.rdy = '0;
        return r;
    endfunction

    task automatic random_rays(int n);
        repeat (n) send_ray(rand_ray());
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        send_ray(make_ray(12'd0, 1'b0, 32'd0, 19'h1_0000, 19'h0_0000));
        send_ray(make_ray(12'hFFF, 1'b1, 32'd1, 19'h3_FFFF, 19'h3_FFFF));
        send_ray(make_ray(12'd5, 1'b0, 32'hFFFF_FFFF, 19'h4_0000, 19'h4_0000));
        send_ray(make_ray(12'd6, 1'b1, 32'hFFFF_FFFF, 19'h3_FFFF, 19'h4_0000));
        send_ray(make_ray(12'd7, 1'b0, 32'h1_0000, 19'h0_0000, 19'h3_FFFF));
        send_ray(make_ray(12'd8, 1'b1, 32'h1_0000, 19'h0_0000, 19'h0_0000));
        send_ray(make_ray(12'd9, 1'b0, 32'h0_8000, 19'h7_0000, 19'h6_8000));
        send_ray(make_ray(12'd10, 1'b1, 32'h0_0400, 19'h0_4000, 19'h7_C000));
        send_ray(make_ray(12'd11, 1'b0, 32'h0_0040, 19'h0_0001, 19'h7_FFFF));
        send_ray(make_ray(12'd12, 1'b1, 32'h2_0000, 19'h7_FFFF, 19'h0_0001));
        random_rays(250);
        setup(32'd0, 32'd4096, 32'd4096, 32'h0005_8000, 32'h0003_2000);
        send_ray(make_ray(12'd1, 1'b0, 32'd0, 19'h1_0000, 19'h1_0000));
        send_ray(make_ray(12'd2, 1'b1, 32'h1_0000, 19'h4_0000, 19'h3_FFFF));
        random_rays(250);
        setup(32'd1, 32'd1, 32'd1, 32'd0, 32'd0);
        random_rays(240);
        setup(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_ray(make_ray(12'd3, 1'b0, 32'd1, 19'h3_FFFF, 19'h3_FFFF));
        send_ray(make_ray(12'd4, 1'b1, 32'd0, 19'h4_0000, 19'h4_0000));
        random_rays(240);
        setup(32'd4096, 32'd4096, 32'd4096, $urandom, $urandom);
        random_rays(240);
        setup(32'd480, 32'd64, 32'd64, 32'h0010_4000, 32'h0008_C000);
        random_rays(240);
        repeat (2) begin
            setup($urandom, $urandom, $urandom, $urandom, $urandom);
            random_rays(240);
        end
        drain();
        if (board.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
